// File: design/zrle_pkg.sv
// Shared constants and types for the zero run-length encoder.
package zrle_pkg;

    // Symbol width handling.
    localparam int SYMBOL_BITS = 16;
    localparam int CODE_W      = 16;
    localparam logic [CODE_W-1:0] SYM_MASK =
        (SYMBOL_BITS >= CODE_W) ? {CODE_W{1'b1}} : CODE_W'((64'd1 << SYMBOL_BITS) - 64'd1);

    // Code words.
    localparam logic [CODE_W-1:0] ESCAPE_CODE   = {CODE_W{1'b1}};
    localparam logic [CODE_W-1:0] MIN_CODED_RUN = CODE_W'(3);

    // Burst queue geometry.
    localparam int MAX_WORDS  = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // One burst of output words produced by a single item.
    typedef struct packed {
        logic [1:0]                        num_words;
        logic [MAX_WORDS-1:0][CODE_W-1:0]  words;
        logic                              eos;
    } t_burst;

    // Queue status seen by the back end.
    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_status;

endpackage

// File: design/zrle_front.sv
// Front end: accepts symbols, tracks the zero run and builds output bursts.
module zrle_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [zrle_pkg::CODE_W-1:0] i_symbol,
    input  logic                        i_end_of_stream,
    output logic                        o_push,
    output zrle_pkg::t_burst            o_burst
);

    logic [zrle_pkg::CODE_W-1:0] r_count;
    logic [zrle_pkg::CODE_W-1:0] n_count;
    logic [zrle_pkg::CODE_W-1:0] sym;
    logic [zrle_pkg::CODE_W-1:0] inc;
    zrle_pkg::t_burst            burst;

    // Mask the symbol and keep literals clear of the escape code.
    always_comb begin
        sym = i_symbol & zrle_pkg::SYM_MASK;
        if (sym == zrle_pkg::ESCAPE_CODE) begin
            sym = zrle_pkg::ESCAPE_CODE - zrle_pkg::CODE_W'(1);
        end
        inc = r_count + zrle_pkg::CODE_W'(1);
    end

    // Classify the item into a burst of zero to three words.
    always_comb begin
        burst           = '0;
        burst.eos       = i_end_of_stream;
        n_count         = r_count;
        if (sym == '0) begin
            if (inc == zrle_pkg::ESCAPE_CODE) begin
                // The run hit the longest codable length: split it here.
                burst.num_words = 2'd2;
                burst.words[0]  = zrle_pkg::ESCAPE_CODE;
                burst.words[1]  = zrle_pkg::ESCAPE_CODE;
                n_count         = '0;
            end else if (i_end_of_stream) begin
                // Flush the run including this zero.
                if (inc >= zrle_pkg::MIN_CODED_RUN) begin
                    burst.num_words = 2'd2;
                    burst.words[0]  = zrle_pkg::ESCAPE_CODE;
                    burst.words[1]  = inc;
                end else begin
                    burst.num_words = inc[1:0];
                end
                n_count = '0;
            end else begin
                n_count = inc;
            end
        end else begin
            // A nonzero symbol ends the run, then passes through.
            if (r_count >= zrle_pkg::MIN_CODED_RUN) begin
                burst.num_words = 2'd3;
                burst.words[0]  = zrle_pkg::ESCAPE_CODE;
                burst.words[1]  = r_count;
                burst.words[2]  = sym;
            end else begin
                burst.num_words = r_count[1:0] + 2'd1;
                burst.words[r_count[1:0]] = sym;
            end
            n_count = '0;
        end
    end

    // Run counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_accept) begin
            r_count <= n_count;
        end
    end

    assign o_push  = i_accept && (burst.num_words != 2'd0);
    assign o_burst = burst;

endmodule

// File: design/zrle_fifo.sv
// Short queue of bursts between the front end and the back end.
module zrle_fifo (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  zrle_pkg::t_burst        i_burst,
    input  logic                    i_pop,
    output zrle_pkg::t_burst        o_head,
    output zrle_pkg::t_fifo_status  o_status
);

    zrle_pkg::t_burst              r_mem [zrle_pkg::FIFO_DEPTH];
    logic [zrle_pkg::FIFO_AW-1:0]  r_wr_ptr;
    logic [zrle_pkg::FIFO_AW-1:0]  r_rd_ptr;
    logic [zrle_pkg::FIFO_AW:0]    r_fill;
    logic                          do_push;
    logic                          do_pop;

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_burst;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + zrle_pkg::FIFO_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + zrle_pkg::FIFO_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + (zrle_pkg::FIFO_AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - (zrle_pkg::FIFO_AW+1)'(1);
            end
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_fill == '0);
    assign o_status.full  = (r_fill == (zrle_pkg::FIFO_AW+1)'(zrle_pkg::FIFO_DEPTH));

endmodule

// File: design/zrle_back.sv
// Back end: unpacks queued bursts into one output item per cycle while the output is not stalled.
module zrle_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  zrle_pkg::t_burst            i_head,
    input  zrle_pkg::t_fifo_status      i_status,
    output logic                        o_pop,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic [zrle_pkg::CODE_W-1:0] o_code,
    output logic                        o_last_of_burst,
    output logic                        o_stream_done
);

    logic                        r_valid;
    logic [zrle_pkg::CODE_W-1:0] r_code;
    logic                        r_last;
    logic                        r_done;
    logic [1:0]                  r_idx;
    logic                        load;
    logic                        final_word;

    // Load the output register from the queue head whenever a burst is queued and the register is empty or being taken.
    assign load       = !i_status.empty && (!r_valid || !i_stall);
    assign final_word = (r_idx == (i_head.num_words - 2'd1));
    assign o_pop      = load && final_word;

    // Control: output valid and word index within the head burst.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= final_word ? 2'd0 : r_idx + 2'd1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Payload of the output register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_code <= i_head.words[r_idx];
            r_last <= final_word;
            r_done <= final_word && i_head.eos;
        end
    end

    assign o_valid         = r_valid;
    assign o_code          = r_code;
    assign o_last_of_burst = r_last;
    assign o_stream_done   = r_done;

endmodule

// File: design/zero_run_length_encoder_core.sv
// Top level of the zero run-length encoder: front end, burst queue, back end.
//
//  Channel  Direction  Handshake           Payload
//  input    in         i_valid / o_stall   i_symbol, i_end_of_stream
//  output   out        o_valid / i_stall   o_code, o_last_of_burst, o_stream_done
//
// An item is taken every cycle while the four-entry burst queue has room.
// Each item yields zero to three output items; the back end sends one per cycle while not stalled.
// An item's burst is written into the queue when the item is taken, then its words pass through the output register.
// Reset is synchronous, active low, and clears the run count and the queue.
// Output stalls hold the output register; the queue fills and then o_stall rises.
module zero_run_length_encoder_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [zrle_pkg::CODE_W-1:0] i_symbol,
    input  logic                        i_end_of_stream,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [zrle_pkg::CODE_W-1:0] o_code,
    output logic                        o_last_of_burst,
    output logic                        o_stream_done
);

    zrle_pkg::t_burst       burst;
    zrle_pkg::t_burst       head;
    zrle_pkg::t_fifo_status status;
    logic                   push;
    logic                   pop;
    logic                   accept;

    // Input items are taken whenever the queue is not full.
    assign o_stall = status.full;
    assign accept  = i_valid && !status.full;

    zrle_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_symbol        (i_symbol),
        .i_end_of_stream (i_end_of_stream),
        .o_push          (push),
        .o_burst         (burst)
    );

    zrle_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_burst  (burst),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (status)
    );

    zrle_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_status        (status),
        .o_pop           (pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_code          (o_code),
        .o_last_of_burst (o_last_of_burst),
        .o_stream_done   (o_stream_done)
    );

endmodule

// File: bench/zrle_stream_checker.sv
// Stream checker for the zero run-length encoder: predicts every code word and compares.
module zrle_stream_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic [zrle_pkg::CODE_W-1:0] i_symbol,
    input  logic                        i_end_of_stream,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [zrle_pkg::CODE_W-1:0] i_code,
    input  logic                        i_last_of_burst,
    input  logic                        i_stream_done,
    output int                          o_errors,
    output int                          o_pending
);
    import zrle_pkg::*;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
        logic              done;
    } t_coded_word;

    // Code words still owed by the encoder, oldest first.
    t_coded_word       expected_codes[$];
    // Code words caused by the item being encoded.
    t_coded_word       item_codes[$];
    logic [CODE_W-1:0] zero_run = '0;
    int                mismatches = 0;

    assign o_errors = mismatches;

    task automatic push_code(input logic [CODE_W-1:0] word);
        t_coded_word entry;
        entry.code = word;
        entry.last = 1'b0;
        entry.done = 1'b0;
        item_codes.insert(item_codes.size(), entry);
    endtask

    // Emit the pending zero run, either escaped with its length or as literal zeros.
    task automatic flush_zero_run();
        if (zero_run >= MIN_CODED_RUN) begin
            push_code(ESCAPE_CODE);
            push_code(zero_run);
        end else begin
            repeat (zero_run) push_code('0);
        end
        zero_run = '0;
    endtask

    // Work out the code words that one accepted symbol causes.
    task automatic encode_symbol(input logic [CODE_W-1:0] raw, input logic eos);
        logic [CODE_W-1:0] sym;
        item_codes.delete();
        sym = raw & SYM_MASK;
        // A literal must never look like the escape word.
        if (sym == ESCAPE_CODE)
            sym = ESCAPE_CODE - 1'b1;
        if (sym == '0) begin
            zero_run = zero_run + 1'b1;
            // A full-length run is split off at once.
            if (zero_run == ESCAPE_CODE) begin
                push_code(ESCAPE_CODE);
                push_code(ESCAPE_CODE);
                zero_run = '0;
            end
            if (eos)
                flush_zero_run();
        end else begin
            flush_zero_run();
            push_code(sym);
        end
        if (item_codes.size() != 0) begin
            item_codes[item_codes.size() - 1].last = 1'b1;
            item_codes[item_codes.size() - 1].done = eos;
        end
        expected_codes = {expected_codes, item_codes};
    endtask

    // Watch both channels on every rising edge.
    always @(posedge i_clk) begin : monitor
        t_coded_word want;
        if (!i_rst_n) begin
            zero_run = '0;
            expected_codes.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                encode_symbol(i_symbol, i_end_of_stream);
            if (i_out_valid && !i_out_stall) begin
                if (expected_codes.size() == 0) begin
                    $display("%0t: expected no output item, got code %h last %b done %b",
                             $time, i_code, i_last_of_burst, i_stream_done);
                    mismatches++;
                end else begin
                    want = expected_codes.pop_front();
                    if (i_code !== want.code) begin
                        $display("%0t: code expected %h, got %h", $time, want.code, i_code);
                        mismatches++;
                    end
                    if (i_last_of_burst !== want.last) begin
                        $display("%0t: last_of_burst expected %b, got %b",
                                 $time, want.last, i_last_of_burst);
                        mismatches++;
                    end
                    if (i_stream_done !== want.done) begin
                        $display("%0t: stream_done expected %b, got %b",
                                 $time, want.done, i_stream_done);
                        mismatches++;
                    end
                end
            end
        end
        o_pending <= expected_codes.size();
    end

endmodule

// File: bench/zero_run_length_encoder_core_test.sv
// Testbench top for the zero run-length encoder: stimulus, output stalls, watchdog and verdict.
module zero_run_length_encoder_core_test;
    import zrle_pkg::*;

    localparam int RANDOM_ITEMS = 450;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 20;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              sym_valid = 1'b0;
    logic              sym_stall;
    logic [CODE_W-1:0] symbol = '0;
    logic              end_of_stream = 1'b0;
    logic              code_valid;
    logic              code_stall = 1'b0;
    logic [CODE_W-1:0] code;
    logic              last_of_burst;
    logic              stream_done;
    int                errors;
    int                pending;
    int                items_sent = 0;
    int                quiet_cycles = 0;

    zero_run_length_encoder_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (sym_valid),
        .o_stall         (sym_stall),
        .i_symbol        (symbol),
        .i_end_of_stream (end_of_stream),
        .o_valid         (code_valid),
        .i_stall         (code_stall),
        .o_code          (code),
        .o_last_of_burst (last_of_burst),
        .o_stream_done   (stream_done)
    );

    zrle_stream_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (sym_valid),
        .i_in_stall      (sym_stall),
        .i_symbol        (symbol),
        .i_end_of_stream (end_of_stream),
        .i_out_valid     (code_valid),
        .i_out_stall     (code_stall),
        .i_code          (code),
        .i_last_of_burst (last_of_burst),
        .i_stream_done   (stream_done),
        .o_errors        (errors),
        .o_pending       (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Present one symbol after an optional idle gap and wait until it is taken.
    task automatic send_item(input logic [CODE_W-1:0] sym, input logic eos, input int gap);
        repeat (gap) begin
            @(negedge clk);
            sym_valid = 1'b0;
        end
        @(negedge clk);
        sym_valid     = 1'b1;
        symbol        = sym;
        end_of_stream = eos;
        do @(posedge clk); while (sym_stall);
        items_sent++;
    endtask

    // Output side stalls in phases: free running, choppy, or held for a while.
    initial begin : stall_driver
        int hold;
        int r;
        hold = 0;
        forever begin
            @(negedge clk);
            if (hold > 0) begin
                hold--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    code_stall = 1'b0;
                    hold       = $urandom_range(0, 8);
                end else if (r < 85) begin
                    code_stall = 1'b1;
                    hold       = $urandom_range(0, 3);
                end else if (r < 95) begin
                    code_stall = 1'b1;
                    hold       = $urandom_range(5, 30);
                end else begin
                    code_stall = 1'b0;
                    hold       = $urandom_range(30, 150);
                end
            end
        end
    end

    // End the run if neither channel moves for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((sym_valid && !sym_stall) || (code_valid && !code_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("zero_run_length_encoder_core_test: FAIL");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int                random_start;
        int                run;
        int                r;
        int                gap;
        logic              steady;
        logic [CODE_W-1:0] sym;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Literals at the edges of the range, the escape collision and alternating bits.
        send_item(16'h0001, 1'b0, 0);
        send_item(16'hFFFE, 1'b0, 0);
        send_item(16'hFFFF, 1'b0, 1);
        send_item(16'h5555, 1'b0, 0);
        send_item(16'hAAAA, 1'b0, 0);
        // Runs of one, two and three zeros ended by a literal.
        send_item('0, 1'b0, 0);
        send_item(16'h0007, 1'b0, 0);
        send_item('0, 1'b0, 2);
        send_item('0, 1'b0, 0);
        send_item(16'h8000, 1'b0, 0);
        send_item('0, 1'b0, 0);
        send_item('0, 1'b0, 0);
        send_item('0, 1'b0, 0);
        send_item(16'h0001, 1'b0, 0);
        // End of stream on a zero flushes an escaped run.
        repeat (3) send_item('0, 1'b0, 0);
        send_item('0, 1'b1, 0);
        // End of stream on a literal after a short run and with no run at all, and on short zero runs.
        send_item('0, 1'b0, 0);
        send_item(16'h0009, 1'b1, 0);
        send_item('0, 1'b1, 3);
        send_item(16'h1234, 1'b1, 0);
        send_item('0, 1'b0, 0);
        send_item('0, 1'b1, 0);

        // Random zero runs closed by literals, with some noise.
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 8)) begin
                    gap = steady ? 0 : pick_gap();
                    send_item(CODE_W'($urandom_range(0, 65535)),
                              ($urandom_range(0, 9) == 0), gap);
                end
            end else begin
                r   = $urandom_range(0, 9);
                run = (r < 4) ? $urandom_range(0, 2) :
                      (r < 8) ? $urandom_range(3, 12) : $urandom_range(13, 40);
                repeat (run) begin
                    gap = steady ? 0 : pick_gap();
                    send_item('0, ($urandom_range(0, 49) == 0), gap);
                end
                r = $urandom_range(0, 19);
                if (r == 0)
                    sym = 16'hFFFF;
                else if (r == 1)
                    sym = 16'hFFFE;
                else if (r < 8)
                    sym = CODE_W'($urandom_range(1, 15));
                else
                    sym = CODE_W'($urandom_range(1, 65535));
                gap = steady ? 0 : pick_gap();
                send_item(sym, ($urandom_range(0, 14) == 0), gap);
            end
        end

        @(negedge clk);
        sym_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("zero_run_length_encoder_core_test: PASS");
        else
            $display("zero_run_length_encoder_core_test: FAIL");
        $finish;
    end

endmodule

// File: sim.f
design/zrle_pkg.sv
design/zrle_front.sv
design/zrle_fifo.sv
design/zrle_back.sv
design/zero_run_length_encoder_core.sv
bench/zrle_stream_checker.sv
bench/zero_run_length_encoder_core_test.sv
